### rtl/lsd_pkg.sv
// ----------------------------------------------------------------------------
// LZSS sprite decompressor package
// Shared constants, command codes and the command word carried from the
// parser to the pixel engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lsd_pkg;

  // History window geometry and start-of-sprite contents.
  localparam int          WIN_BITS    = 12;
  localparam int          WINDOW_SIZE = 1 << WIN_BITS;
  localparam logic [11:0] WIN_START   = 12'd4078;
  localparam logic [7:0]  FILL_BYTE   = 8'h20;

  // A match copies its length field plus this many pixels.
  localparam logic [4:0]  MATCH_MIN   = 5'd3;

  // Command queue between the parser and the pixel engine.
  localparam int          QUEUE_DEPTH = 4;
  localparam int          QPTR_BITS   = 2;

  // Command kinds.
  localparam logic [1:0]  CMD_START   = 2'd0;
  localparam logic [1:0]  CMD_LIT     = 2'd1;
  localparam logic [1:0]  CMD_MATCH   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0]  REG_WIDTH   = 2'd0;
  localparam logic [1:0]  REG_HEIGHT  = 2'd1;
  localparam logic [1:0]  REG_COUNT   = 2'd2;
  localparam logic [1:0]  REG_TRANSP  = 2'd3;

  // A literal keeps its byte in arg[7:0]; a match keeps its window position
  // in arg[15:4] and its length field in arg[3:0].
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] arg;
  } lsd_cmd_t;

endpackage

`default_nettype wire

### rtl/lsd_front.sv
// ----------------------------------------------------------------------------
// LZSS stream parser
// Accepts compressed words, tracks flag bits and match halves, and turns the
// stream into start, literal and match commands for the pixel engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_front import lsd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     command,
  input  wire logic [7:0] data_byte,
  input  wire logic     full,
  output logic          push,
  output lsd_cmd_t      push_cmd
);

  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_ITEM  = 2'd1;
  localparam logic [1:0] PH_MATCH = 2'd2;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [8:0] flag_shift;
  logic [8:0] flag_shift_next;
  logic [7:0] match_low;
  logic [7:0] match_low_next;
  logic [8:0] shifted;
  logic       accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign shifted  = {1'b0, flag_shift[8:1]};

  always_comb begin
    phase_next      = phase;
    flag_shift_next = flag_shift;
    match_low_next  = match_low;
    push            = 1'b0;
    push_cmd.kind   = CMD_START;
    push_cmd.arg    = 16'd0;
    if (accept) begin
      if (!command) begin
        phase_next      = PH_FLAG;
        flag_shift_next = 9'd0;
        match_low_next  = 8'd0;
        push            = 1'b1;
      end else begin
        unique case (phase)
          PH_ITEM: begin
            if (flag_shift[0]) begin
              push            = 1'b1;
              push_cmd.kind   = CMD_LIT;
              push_cmd.arg    = {8'd0, data_byte};
              flag_shift_next = shifted;
              phase_next      = (shifted <= 9'd1) ? PH_FLAG : PH_ITEM;
            end else begin
              match_low_next = data_byte;
              phase_next     = PH_MATCH;
            end
          end
          PH_MATCH: begin
            push            = 1'b1;
            push_cmd.kind   = CMD_MATCH;
            push_cmd.arg    = {data_byte[7:4], match_low, data_byte[3:0]};
            flag_shift_next = shifted;
            phase_next      = (shifted <= 9'd1) ? PH_FLAG : PH_ITEM;
          end
          default: begin
            // A flag byte: the marker bit above bit 7 counts eight items.
            flag_shift_next = {1'b1, data_byte};
            phase_next      = PH_ITEM;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FLAG;
      flag_shift <= 9'd0;
      match_low  <= 8'd0;
    end else begin
      phase      <= phase_next;
      flag_shift <= flag_shift_next;
      match_low  <= match_low_next;
    end
  end

endmodule

`default_nettype wire

### rtl/lsd_queue.sv
// ----------------------------------------------------------------------------
// LZSS command queue
// A short first-in first-out buffer that lets the parser run ahead of the
// pixel engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_queue import lsd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire lsd_cmd_t push_cmd,
  output logic          full,
  input  wire logic     pop,
  output lsd_cmd_t      head,
  output logic          head_valid
);

  lsd_cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QPTR_BITS:0]    count;
  logic                  do_push;
  logic                  do_pop;

  assign full       = (count == QUEUE_DEPTH[QPTR_BITS:0]);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### rtl/lsd_back.sv
// ----------------------------------------------------------------------------
// LZSS pixel engine
// Carries out start, literal and match commands: owns the history window,
// the sprite position counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_back import lsd_pkg::*; #(
  parameter int DIM_BITS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lsd_cmd_t            head,
  input  wire logic                head_valid,
  output logic                     pop,
  input  wire logic [DIM_BITS-1:0] sprite_width,
  input  wire logic [DIM_BITS-1:0] sprite_height,
  input  wire logic [15:0]         pixel_count,
  input  wire logic                transparent_mode,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               pixel,
  output logic [DIM_BITS-1:0]      column,
  output logic [DIM_BITS-1:0]      row,
  output logic                     write_enable,
  output logic                     last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_COPY = 1'b1;

  logic                state;
  logic                finished;
  logic [WIN_BITS-1:0] wr_pos;
  logic [WIN_BITS:0]   fill_count;
  logic [DIM_BITS-1:0] cur_col;
  logic [DIM_BITS-1:0] cur_row;
  logic [15:0]         remaining;
  logic [WIN_BITS-1:0] rd_addr;
  logic [4:0]          len_left;
  logic                pend;
  logic                byp_hit;
  logic [7:0]          byp_data;
  logic                unwritten;
  logic [7:0]          rd_q;
  logic [7:0]          win [WINDOW_SIZE];

  logic                can_emit;
  logic                is_lit;
  logic                emit;
  logic [7:0]          emit_val;
  logic [DIM_BITS-1:0] col_inc;
  logic [DIM_BITS-1:0] row_inc;
  logic                wrap;
  logic                end_rows;
  logic [15:0]         rem_dec;
  logic                done;
  logic                issue;
  logic [WIN_BITS-1:0] rd_off;
  logic                rd_written;
  logic                win_we;

  assign can_emit = !out_valid || !out_stall;
  assign is_lit   = (state == ST_IDLE) && head_valid && (head.kind == CMD_LIT) && !finished;
  assign emit     = (state == ST_COPY) ? (pend && can_emit) : (is_lit && can_emit);
  assign emit_val = (state == ST_COPY) ?
                    (byp_hit ? byp_data : (unwritten ? FILL_BYTE : rd_q)) : head.arg[7:0];

  assign col_inc  = cur_col + 1'b1;
  assign row_inc  = cur_row + 1'b1;
  assign wrap     = (col_inc >= sprite_width);
  assign end_rows = wrap && (row_inc >= sprite_height);
  assign rem_dec  = remaining - 16'd1;
  assign done     = end_rows || (rem_dec == 16'd0);
  assign win_we   = emit && !done;

  assign issue = (state == ST_COPY) && (len_left != 5'd0) && (!pend || emit) && !(emit && done);
  assign pop   = (state == ST_IDLE) && head_valid && !(is_lit && !can_emit);

  // Entries are written in order from the start position, so those written
  // since the last start form one run of fill_count entries.
  assign rd_off     = rd_addr - WIN_START;
  assign rd_written = ({1'b0, rd_off} < fill_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      finished   <= 1'b1;
      wr_pos     <= WIN_START;
      fill_count <= '0;
      cur_col    <= '0;
      cur_row    <= '0;
      remaining  <= 16'd0;
      len_left   <= 5'd0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (emit) begin
        cur_col <= wrap ? '0 : col_inc;
        cur_row <= wrap ? row_inc : cur_row;
        if (!end_rows) begin
          remaining <= rem_dec;
        end
        if (done) begin
          finished <= 1'b1;
        end else begin
          wr_pos <= wr_pos + 1'b1;
          if (fill_count != WINDOW_SIZE[WIN_BITS:0]) begin
            fill_count <= fill_count + 1'b1;
          end
        end
      end

      unique case (state)
        ST_COPY: begin
          if (issue) begin
            rd_addr  <= rd_addr + 1'b1;
            len_left <= len_left - 1'b1;
            pend     <= 1'b1;
          end else if (emit) begin
            pend <= 1'b0;
          end
          if (emit && (done || len_left == 5'd0)) begin
            state <= ST_IDLE;
            pend  <= 1'b0;
          end
        end
        default: begin
          if (pop && head.kind == CMD_START) begin
            finished   <= 1'b0;
            wr_pos     <= WIN_START;
            fill_count <= '0;
            cur_col    <= '0;
            cur_row    <= '0;
            remaining  <= pixel_count;
          end else if (pop && head.kind == CMD_MATCH && !finished) begin
            state    <= ST_COPY;
            rd_addr  <= head.arg[15:4];
            len_left <= {1'b0, head.arg[3:0]} + MATCH_MIN;
            pend     <= 1'b0;
          end
        end
      endcase
    end
  end

  // Output payload and read-side payload registers.
  always_ff @(posedge clk) begin
    if (emit) begin
      pixel        <= emit_val;
      column       <= cur_col;
      row          <= cur_row;
      write_enable <= (emit_val != 8'd0) || !transparent_mode;
      last         <= done;
    end
    if (issue) begin
      // The pixel written in this cycle is the one the read may target.
      byp_hit   <= emit && (rd_addr == wr_pos);
      byp_data  <= emit_val;
      unwritten <= !rd_written;
    end
  end

  // History window: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (win_we) begin
      win[wr_pos] <= emit_val;
    end
    if (issue) begin
      rd_q <= win[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/lzss_sprite_decompressor_core.sv
// A literal word reaches the pixel output through the command queue and the output
// register; a match also passes through the copy state and the window read register.
// Throughput: one pixel per cycle during a match copy while the output is not stalled,
// limited by the single read port of the history window.
// Reset is synchronous and active high; the window needs no clearing pass,
// since a fill count marks which entries were written since the last start.
// ----------------------------------------------------------------------------
// LZSS sprite decompressor, top level
// Decodes an LZSS-compressed sprite stream with a 4096-byte history window
// into pixels tagged with their column, row, write enable and end marker.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_sprite_decompressor_core import lsd_pkg::*; #(
  parameter int DIM_BITS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Configuration write port.
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  // Input channel: one compressed word per handshake.
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                command,
  input  wire logic [7:0]          data_byte,
  // Output channel: one pixel word per handshake.
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               pixel,
  output logic [DIM_BITS-1:0]      column,
  output logic [DIM_BITS-1:0]      row,
  output logic                     write_enable,
  output logic                     last
);

  // The design is split into a parser, which classifies each accepted word
  // and keeps the flag and match-half state, and a pixel engine, which owns
  // the window and the sprite counters. A four-entry queue lets the parser
  // keep taking words while the engine is busy copying a long match, and
  // lets the engine drain while the input side is idle.

  logic [DIM_BITS-1:0] sprite_width;
  logic [DIM_BITS-1:0] sprite_height;
  logic [15:0]         pixel_count;
  logic                transparent_mode;

  logic     push;
  lsd_cmd_t push_cmd;
  logic     full;
  logic     pop;
  lsd_cmd_t head;
  logic     head_valid;

  // Configuration registers. Width, height and transparency are read live by
  // the engine; the pixel count is sampled when a start word is carried out.
  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_width     <= DIM_BITS'(1);
      sprite_height    <= DIM_BITS'(1);
      pixel_count      <= 16'd0;
      transparent_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH:  sprite_width     <= cfg_data[DIM_BITS-1:0];
        REG_HEIGHT: sprite_height    <= cfg_data[DIM_BITS-1:0];
        REG_COUNT:  pixel_count      <= cfg_data;
        REG_TRANSP: transparent_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .data_byte (data_byte),
    .full      (full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  lsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // The engine drops literal and match commands once the sprite has ended,
  // until the next start word arrives.
  lsd_back #(
    .DIM_BITS (DIM_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .head_valid       (head_valid),
    .pop              (pop),
    .sprite_width     (sprite_width),
    .sprite_height    (sprite_height),
    .pixel_count      (pixel_count),
    .transparent_mode (transparent_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pixel            (pixel),
    .column           (column),
    .row              (row),
    .write_enable     (write_enable),
    .last             (last)
  );

endmodule

`default_nettype wire

### rtl/lsd_checker.sv
// ----------------------------------------------------------------------------
// LZSS sprite decompressor checker
// Port-level assertions on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_checker #(
  parameter int DIM_BITS = 10
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [7:0]          pixel,
  input wire logic [DIM_BITS-1:0] column,
  input wire logic [DIM_BITS-1:0] row,
  input wire logic                write_enable,
  input wire logic                last
);

  // A stalled pixel word holds until taken.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel) && $stable(column)
                               && $stable(row) && $stable(last))
    else $error("stalled pixel word changed");

  // Only a zero pixel is ever suppressed.
  a_transp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> pixel == 8'd0)
    else $error("non-zero pixel marked transparent");

  // Column and row never reach all ones: the width and height registers
  // hold no larger value, and a position that reaches them wraps or ends
  // the sprite.
  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (column != '1) && (row != '1))
    else $error("pixel position out of range");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind lzss_sprite_decompressor_core lsd_checker #(
  .DIM_BITS (DIM_BITS)
) u_lsd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pixel        (pixel),
  .column       (column),
  .row          (row),
  .write_enable (write_enable),
  .last         (last)
);

`default_nettype wire
